// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rcf_pkg.sv =====
`timescale 1ns / 1ps

package rcf_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned POS_W       = 33;

   localparam logic [31:0] TARGET_RESET = 32'h64617461;  // "data"
   localparam logic [31:0] TAG_RIFF     = 32'h52494646;
   localparam logic [31:0] TAG_RIFX     = 32'h52494658;
   localparam logic [7:0]  CHAR_X       = 8'h58;

   localparam logic [CSR_ADDR_W-3:0] REG_TARGET_TAG = '0;

   localparam logic [1:0] STATUS_FOUND      = 2'd0;
   localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND  = 2'd2;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] chunk_size;
      logic        big_endian;
      logic [31:0] form_type;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      req_type          req;
      logic [3:0]       hdr_idx;
      logic [POS_W-1:0] pos_next;
   } tok_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // size field accumulation in the file's byte order
   function automatic logic [31:0] size_acc(input logic [31:0] acc, input logic [7:0] b,
                                            input logic big);
      if (big) begin
         return {acc[23:0], b};
      end
      return {b, acc[31:8]};
   endfunction

endpackage

// ===== rtl/rcf_front.sv =====
`timescale 1ns / 1ps

module rcf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  rcf_pkg::req_type      req_payload,
   output logic                  req_stall,
   input  rcf_pkg::q_status_type q_status,
   output logic                  push,
   output rcf_pkg::tok_type      tok
);

   logic [rcf_pkg::POS_W-1:0] pos_ff, pos_in, pos_sat;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      // position saturates so end compares stay exact
      pos_sat = (pos_ff == '1) ? pos_ff : pos_ff + rcf_pkg::POS_W'(1);
      pos_in  = pos_ff;
      if (push) begin
         pos_in = req_payload.stream_last ? '0 : pos_sat;
      end
      tok.req      = req_payload;
      tok.pos_next = pos_sat;
      tok.hdr_idx  = (pos_ff < rcf_pkg::POS_W'(16)) ? pos_ff[3:0] : 4'hF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== rtl/rcf_queue.sv =====
`timescale 1ns / 1ps

module rcf_queue #(
   parameter int unsigned DEPTH = rcf_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rcf_pkg::tok_type      tok_in,
   input  logic                  pop,
   output rcf_pkg::tok_type      tok_out,
   output rcf_pkg::q_status_type q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rcf_pkg::tok_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign q_status.full  = (count_ff == CNT_W'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign tok_out        = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rcf_back.sv =====
`timescale 1ns / 1ps

module rcf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rcf_pkg::tok_type      tok,
   input  rcf_pkg::q_status_type q_status,
   output logic                  pop,
   input  logic [31:0]           target_tag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rcf_pkg::rsp_type      rsp_payload
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_DESC,
      PH_SKIP,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [31:0]      field_ff, field_in;
   logic [31:0]      size_ff, size_in;
   logic             big_ff, big_in;
   logic [31:0]      form_ff, form_in;
   logic             match_ff, match_in;
   logic [31:0]      skip_ff, skip_in;
   logic [2:0]       desc_idx_ff, desc_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rcf_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]  b;
   logic        last;
   logic [31:0] shifted, acc;
   logic        at_end, emit;
   logic [1:0]  st;
   logic [31:0] size_out;

   assign pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      b       = tok.req.stream_byte;
      last    = tok.req.stream_last;
      shifted = {field_ff[23:0], b};
      acc     = rcf_pkg::size_acc(field_ff, b, big_ff);
      at_end  = tok.pos_next >= ({1'b0, size_ff} + 33'd8);

      phase_in     = phase_ff;
      field_in     = field_ff;
      size_in      = size_ff;
      big_in       = big_ff;
      form_in      = form_ff;
      match_in     = match_ff;
      skip_in      = skip_ff;
      desc_idx_in  = desc_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      emit         = 1'b0;
      st           = rcf_pkg::STATUS_FOUND;
      size_out     = '0;

      if (pop) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (tok.hdr_idx < 4'd4) begin
                  field_in = shifted;
                  if (tok.hdr_idx == 4'd3) begin
                     match_in = (shifted == rcf_pkg::TAG_RIFF) ||
                                (shifted == rcf_pkg::TAG_RIFX);
                     big_in   = (b == rcf_pkg::CHAR_X);
                  end
               end else if (tok.hdr_idx < 4'd8) begin
                  size_in = rcf_pkg::size_acc(size_ff, b, big_ff);
               end else begin
                  form_in = {form_ff[23:0], b};
               end
               if (tok.hdr_idx >= 4'd11) begin
                  if (!match_ff) begin
                     emit = 1'b1;
                     st   = rcf_pkg::STATUS_BAD_HEADER;
                  end else if (at_end) begin
                     emit = 1'b1;
                     st   = rcf_pkg::STATUS_NOT_FOUND;
                  end else begin
                     phase_in    = PH_DESC;
                     desc_idx_in = '0;
                  end
               end
            end
            PH_DESC: begin
               desc_idx_in = desc_idx_ff + 3'd1;
               if (desc_idx_ff < 3'd4) begin
                  field_in = shifted;
                  if (desc_idx_ff == 3'd3) begin
                     match_in = (shifted == target_tag);
                  end
               end else begin
                  field_in = acc;
               end
               if (desc_idx_ff == 3'd7) begin
                  if (match_ff) begin
                     emit     = 1'b1;
                     st       = rcf_pkg::STATUS_FOUND;
                     size_out = acc;
                  end else if (acc == '0) begin
                     // empty chunk: straight to the end check
                     if (at_end) begin
                        emit = 1'b1;
                        st   = rcf_pkg::STATUS_NOT_FOUND;
                     end
                  end else begin
                     skip_in  = acc;
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  if (at_end) begin
                     emit = 1'b1;
                     st   = rcf_pkg::STATUS_NOT_FOUND;
                  end else begin
                     phase_in    = PH_DESC;
                     desc_idx_in = '0;
                  end
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         // buffer ran out before a verdict
         if (!emit && last && phase_in != PH_DONE) begin
            emit = 1'b1;
            st   = (phase_in == PH_HEADER) ? rcf_pkg::STATUS_BAD_HEADER
                                           : rcf_pkg::STATUS_NOT_FOUND;
         end

         if (emit) begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = st;
            rsp_in.chunk_size = size_out;
            rsp_in.big_endian = (st == rcf_pkg::STATUS_BAD_HEADER) ? 1'b0 : big_in;
            rsp_in.form_type  = (st == rcf_pkg::STATUS_BAD_HEADER) ? '0 : form_in;
            phase_in          = PH_DONE;
         end

         if (last) begin
            phase_in    = PH_HEADER;
            field_in    = '0;
            size_in     = '0;
            big_in      = 1'b0;
            form_in     = '0;
            match_in    = 1'b0;
            skip_in     = '0;
            desc_idx_in = '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         field_ff     <= '0;
         size_ff      <= '0;
         big_ff       <= 1'b0;
         form_ff      <= '0;
         match_ff     <= 1'b0;
         skip_ff      <= '0;
         desc_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         field_ff     <= field_in;
         size_ff      <= size_in;
         big_ff       <= big_in;
         form_ff      <= form_in;
         match_ff     <= match_in;
         skip_ff      <= skip_in;
         desc_idx_ff  <= desc_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/riff_chunk_finder.sv =====
// the request byte that settles the file goes through the queue, and its result
// through the result register; throughput: one byte per cycle while no result is
// held by rsp_stall, set by the single-byte step of the chunk walker
// a small queue between byte intake and walker absorbs result-side stalls
// reset: synchronous, active high; clears the walker, queue and position count
// and loads target_tag with "data"; no clearing pass, ready the cycle after reset
`timescale 1ns / 1ps

module riff_chunk_finder #(
   parameter int unsigned QUEUE_DEPTH = rcf_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // byte stream requests
   input  logic                           req_valid,
   output logic                           req_stall,
   input  rcf_pkg::req_type               req_payload,
   // results, at most one per file
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output rcf_pkg::rsp_type               rsp_payload,
   // register port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rcf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   logic [31:0] target_ff, target_in;
   logic        csr_hit, csr_wr;

   rcf_pkg::q_status_type q_status;
   rcf_pkg::tok_type      tok_wr, tok_rd;
   logic                  push, pop;

   // single register, decoded on the word address
   assign csr_hit = (paddr[rcf_pkg::CSR_ADDR_W-1:2] == rcf_pkg::REG_TARGET_TAG);
   assign csr_wr  = psel && penable && pwrite && pready && csr_hit;
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? target_ff : '0;

   always_comb begin
      target_in = target_ff;
      if (csr_wr) begin
         target_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= rcf_pkg::TARGET_RESET;
      end else begin
         target_ff <= target_in;
      end
   end

   // front: takes bytes and tags each with its file position
   rcf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_payload(req_payload),
      .req_stall  (req_stall),
      .q_status   (q_status),
      .push       (push),
      .tok        (tok_wr)
   );

   // decoupling queue between intake and walker
   rcf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .tok_in  (tok_wr),
      .pop     (pop),
      .tok_out (tok_rd),
      .q_status(q_status)
   );

   // back: header check, descriptor walk and payload skip, with result register
   rcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tok        (tok_rd),
      .q_status   (q_status),
      .pop        (pop),
      .target_tag (target_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

// ===== rtl/rcf_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rcf_pkg::rsp_type rsp_payload
);

   logic rsp_held, status_known, bad_header, bad_header_clean, not_found;

   assign rsp_held         = rsp_valid && rsp_stall;
   assign status_known     = (rsp_payload.status == rcf_pkg::STATUS_FOUND) ||
                             (rsp_payload.status == rcf_pkg::STATUS_BAD_HEADER) ||
                             (rsp_payload.status == rcf_pkg::STATUS_NOT_FOUND);
   assign bad_header       = rsp_valid && (rsp_payload.status == rcf_pkg::STATUS_BAD_HEADER);
   assign bad_header_clean = (rsp_payload.chunk_size == '0) && !rsp_payload.big_endian &&
                             (rsp_payload.form_type == '0);
   assign not_found        = rsp_valid && (rsp_payload.status == rcf_pkg::STATUS_NOT_FOUND);

   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_payload), "stalled result changed")
   `ASSERT_IMP(a_status_code, clock, reset, rsp_valid, status_known, "undefined status")
   `ASSERT_IMP(a_bad_header_clean, clock, reset, bad_header, bad_header_clean, "bad header result carries data")
   `ASSERT_IMP(a_not_found_size, clock, reset, not_found, rsp_payload.chunk_size == '0, "not found result carries a size")
   `ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !req_stall && !rsp_valid, "not empty after reset")

endmodule

bind riff_chunk_finder rcf_checker u_rcf_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   // extra cycles after the last expected report: room for the intake queue and the
   // result register to drain, with margin
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned ITEM_TARGET   = 1550;

   // chunk and form tags used to build files
   localparam logic [31:0] TAG_FMT  = 32'h666d7420;  // "fmt "
   localparam logic [31:0] TAG_LIST = 32'h4c495354;  // "LIST"
   localparam logic [31:0] TAG_JUNK = 32'h4a554e4b;  // "JUNK"
   localparam logic [31:0] TAG_WAVE = 32'h57415645;  // "WAVE"
   localparam logic [31:0] TAG_RIFY = 32'h52494659;  // near miss of the header tag

   typedef enum logic [1:0] {WALK_HEADER, WALK_DESC, WALK_SKIP, WALK_DONE} walk_phase_type;

   // tracks the chunk walk byte by byte and holds the reports it predicts
   class chunk_search_board;
      rcf_pkg::rsp_type expected_reports[$];
      logic [31:0]      target;
      walk_phase_type   phase;
      logic [32:0]      pos;
      logic [31:0]      shift_reg;
      logic [31:0]      declared_size;
      logic [31:0]      form;
      logic [31:0]      remaining;
      bit               big;
      bit               matched;
      int unsigned      mismatches;

      function new();
         target = rcf_pkg::TARGET_RESET;
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase = WALK_HEADER;
         pos = '0;
         shift_reg = '0;
         declared_size = '0;
         big = 1'b0;
         form = '0;
         matched = 1'b0;
         remaining = '0;
      endfunction

      function logic [31:0] fold_size(input logic [31:0] acc, input logic [7:0] b);
         if (big) begin
            return {acc[23:0], b};
         end
         return {b, acc[31:8]};
      endfunction

      function void bump_pos();
         if (pos != {33{1'b1}}) begin
            pos = pos + 33'd1;
         end
      endfunction

      // true at or past the declared end, else arms the next descriptor
      function bit end_reached();
         logic [32:0] eof;
         eof = 33'd8 + {1'b0, declared_size};
         if (pos >= eof) begin
            return 1'b1;
         end
         phase = WALK_DESC;
         remaining = 32'd8;
         return 1'b0;
      endfunction

      function void note_byte(input rcf_pkg::req_type r);
         logic [7:0]       b;
         logic [32:0]      p;
         logic [31:0]      used;
         logic [2:0]       k;
         logic [1:0]       status;
         logic [31:0]      found_size;
         bit               emit;
         rcf_pkg::rsp_type want;
         b = r.stream_byte;
         emit = 1'b0;
         status = rcf_pkg::STATUS_FOUND;
         found_size = '0;
         case (phase)
            WALK_HEADER: begin
               p = pos;
               if (p < 4) begin
                  shift_reg = {shift_reg[23:0], b};
                  if (p == 3) begin
                     matched = (shift_reg == rcf_pkg::TAG_RIFF) ||
                               (shift_reg == rcf_pkg::TAG_RIFX);
                     big = (b == rcf_pkg::CHAR_X);
                  end
               end else if (p < 8) begin
                  declared_size = fold_size(declared_size, b);
               end else begin
                  form = {form[23:0], b};
               end
               bump_pos();
               if (p >= 11) begin
                  if (!matched) begin
                     emit = 1'b1;
                     status = rcf_pkg::STATUS_BAD_HEADER;
                  end else if (end_reached()) begin
                     emit = 1'b1;
                     status = rcf_pkg::STATUS_NOT_FOUND;
                  end
               end
            end
            WALK_DESC: begin
               used = 32'd8 - remaining;
               k = used[2:0];
               bump_pos();
               remaining = remaining - 32'd1;
               if (k < 4) begin
                  shift_reg = {shift_reg[23:0], b};
                  if (k == 3) begin
                     matched = (shift_reg == target);
                  end
               end else begin
                  shift_reg = fold_size(shift_reg, b);
               end
               if (k == 7) begin
                  if (matched) begin
                     emit = 1'b1;
                     status = rcf_pkg::STATUS_FOUND;
                     found_size = shift_reg;
                  end else if (shift_reg == 0) begin
                     if (end_reached()) begin
                        emit = 1'b1;
                        status = rcf_pkg::STATUS_NOT_FOUND;
                     end
                  end else begin
                     remaining = shift_reg;
                     phase = WALK_SKIP;
                  end
               end
            end
            WALK_SKIP: begin
               bump_pos();
               if (remaining != 0) begin
                  remaining = remaining - 32'd1;
               end
               if (remaining == 0) begin
                  if (end_reached()) begin
                     emit = 1'b1;
                     status = rcf_pkg::STATUS_NOT_FOUND;
                  end
               end
            end
            default: ;
         endcase
         // buffer ends with nothing reported yet
         if (!emit && r.stream_last && phase != WALK_DONE) begin
            emit = 1'b1;
            status = (phase == WALK_HEADER) ? rcf_pkg::STATUS_BAD_HEADER
                                            : rcf_pkg::STATUS_NOT_FOUND;
         end
         if (emit) begin
            want.status = status;
            want.chunk_size = found_size;
            want.big_endian = (status == rcf_pkg::STATUS_BAD_HEADER) ? 1'b0 : big;
            want.form_type = (status == rcf_pkg::STATUS_BAD_HEADER) ? 32'd0 : form;
            expected_reports.push_back(want);
            phase = WALK_DONE;
         end
         if (r.stream_last) begin
            restart();
         end
      endfunction

      function void check_result(input rcf_pkg::rsp_type got);
         rcf_pkg::rsp_type want;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected report: status %0d size %h big %0b form %h",
                        got.status, got.chunk_size, got.big_endian, got.form_type);
            end
            return;
         end
         want = expected_reports.pop_front();
         if (got.status !== want.status || got.chunk_size !== want.chunk_size ||
             got.big_endian !== want.big_endian || got.form_type !== want.form_type) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("report mismatch: expected status %0d size %h big %0b form %h",
                        want.status, want.chunk_size, want.big_endian, want.form_type);
               $display("                 actual   status %0d size %h big %0b form %h",
                        got.status, got.chunk_size, got.big_endian, got.form_type);
            end
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   rcf_pkg::req_type               req_payload;
   logic                           rsp_valid;
   logic                           rsp_stall;
   rcf_pkg::rsp_type               rsp_payload;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [rcf_pkg::CSR_ADDR_W-1:0] paddr;
   logic [31:0]                    pwdata;
   logic [31:0]                    prdata;
   logic                           pready;

   chunk_search_board board;
   logic [7:0]        file_buf[$];   // bytes of the file being built
   int unsigned       req_gap_mode;  // 0 none, 1 light, 2 heavy
   int unsigned       stall_mode;
   int unsigned       cycle_count = 0;
   int unsigned       sent_bytes = 0;

   riff_chunk_finder uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // often no idle cycle, now and then a short run, rarely a long one
   function automatic int unsigned idle_len(input int unsigned mode);
      if (mode == 0 || $urandom_range(99) >= (mode == 1 ? 20 : 50)) begin
         return 0;
      end
      if ($urandom_range(9) == 0) begin
         return $urandom_range(6, 30);
      end
      return $urandom_range(1, 3);
   endfunction

   // result side back-pressure, one decision per stall run
   initial begin
      int unsigned run;
      int unsigned len;
      run = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (run != 0) begin
            run--;
         end else begin
            len = idle_len(stall_mode);
            rsp_stall <= (len != 0);
            run = (len != 0) ? len - 1 : 0;
         end
      end
   end

   // reports are taken at the edge where valid is high and stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_payload);
      end
   end

   // file building: tags go first character first, sizes in the file's byte order
   function automatic void put_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) begin
         file_buf.push_back(w[8*i +: 8]);
      end
   endfunction

   function automatic void put_size(input logic [31:0] w, input bit big);
      for (int i = 0; i < 4; i++) begin
         file_buf.push_back(big ? w[8*(3-i) +: 8] : w[8*i +: 8]);
      end
   endfunction

   function automatic void put_header(input logic [31:0] tag, input logic [31:0] size,
                                      input logic [31:0] form);
      put_word(tag);
      put_size(size, tag[7:0] == rcf_pkg::CHAR_X);
      put_word(form);
   endfunction

   // descriptor plus a payload that may be shorter than the declared size
   function automatic void put_chunk(input logic [31:0] tag, input logic [31:0] size,
                                     input bit big, input int unsigned payload);
      put_word(tag);
      put_size(size, big);
      repeat (payload) file_buf.push_back(8'($urandom));
   endfunction

   function automatic void put_noise(input int unsigned count);
      repeat (count) file_buf.push_back(8'($urandom));
   endfunction

   function automatic logic [31:0] pick_target();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 32'h0;
      if (roll < 20) return 32'hffffffff;
      if (roll < 35) return rcf_pkg::TARGET_RESET;
      if (roll < 50) return TAG_LIST;
      if (roll < 60) return TAG_FMT;
      return $urandom;
   endfunction

   // one file: mostly well formed with random chunks, some noise and near misses
   function automatic void build_random_file();
      logic [31:0] tags[4];
      logic [31:0] sizes[4];
      logic [31:0] declared;
      int unsigned n;
      int unsigned roll;
      int unsigned cut;
      bit          big;
      file_buf.delete();
      if ($urandom_range(99) < 12) begin
         if ($urandom_range(1) == 1) begin
            put_header(rcf_pkg::TAG_RIFF ^ (32'd1 << $urandom_range(31)), $urandom,
                       $urandom);
            put_noise($urandom_range(0, 10));
         end else begin
            put_noise($urandom_range(1, 24));
         end
         return;
      end
      big = $urandom_range(1);
      n = $urandom_range(0, 4);
      declared = 32'd4;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(99);
         tags[i] = roll < 30 ? board.target : roll < 50 ? TAG_FMT :
                   roll < 70 ? TAG_LIST : roll < 80 ? TAG_JUNK : $urandom;
         roll = $urandom_range(99);
         sizes[i] = roll < 10 ? 32'd0 : roll < 80 ? $urandom_range(1, 12) :
                    roll < 95 ? $urandom_range(13, 40) : $urandom;
         declared = declared + 32'd8 + sizes[i];
      end
      // declared end sometimes short of or past the chunks actually sent
      roll = $urandom_range(99);
      if (roll < 15) begin
         declared = declared - $urandom_range(1, 20);
      end else if (roll < 30) begin
         declared = declared + $urandom_range(1, 20);
      end
      put_header(big ? rcf_pkg::TAG_RIFX : rcf_pkg::TAG_RIFF, declared,
                 $urandom_range(1) ? TAG_WAVE : $urandom);
      for (int i = 0; i < n; i++) begin
         // a huge chunk is cut short, which ends the file
         if (sizes[i] > 40) begin
            put_chunk(tags[i], sizes[i], big, $urandom_range(0, 16));
            break;
         end
         put_chunk(tags[i], sizes[i], big, sizes[i]);
      end
      put_noise($urandom_range(0, 4));
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, file_buf.size());
         while (file_buf.size() > cut) file_buf.pop_back();
      end
   endfunction

   task automatic send_byte(input logic [7:0] value, input logic last);
      int unsigned      gap;
      rcf_pkg::req_type item;
      gap = idle_len(req_gap_mode);
      item.stream_byte = value;
      item.stream_last = last;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(item);
      sent_bytes++;
   endtask

   // close marks the final byte as the end of the buffer
   task automatic send_file(input bit close);
      for (int i = 0; i < file_buf.size(); i++) begin
         send_byte(file_buf[i], close && (i == file_buf.size() - 1));
      end
      file_buf.delete();
   endtask

   // wait for every expected report, then let the intake queue drain
   task automatic settle();
      req_valid <= 1'b0;
      while (board.expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle then access cycle; the write lands on the access edge
   task automatic write_target(input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {rcf_pkg::REG_TARGET_TAG, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      board.target = value;
   endtask

   initial begin
      board = new();
      req_gap_mode = 1;
      stall_mode = 1;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // plain little endian file, target found after a skipped chunk
      put_header(rcf_pkg::TAG_RIFF, 32'd40, TAG_WAVE);
      put_chunk(TAG_FMT, 32'd4, 1'b0, 4);
      put_chunk(rcf_pkg::TARGET_RESET, 32'd16, 1'b0, 16);
      send_file(1'b1);
      // big endian file with all-ones file size, form and target chunk size
      put_header(rcf_pkg::TAG_RIFX, 32'hffffffff, 32'hffffffff);
      put_chunk(TAG_FMT, 32'd2, 1'b1, 2);
      put_chunk(rcf_pkg::TARGET_RESET, 32'hffffffff, 1'b1, 3);
      send_file(1'b1);
      // bad header tag, reported after the twelfth byte
      put_header(TAG_RIFY, 32'd40, 32'h0);
      put_noise(4);
      send_file(1'b1);
      // short headers: seven bytes, then two single-byte files
      put_word(rcf_pkg::TAG_RIFF);
      put_noise(3);
      send_file(1'b1);
      file_buf.push_back(8'h00);
      send_file(1'b1);
      file_buf.push_back(8'hff);
      send_file(1'b1);
      // empty declared body, once with trailing bytes, once ending on the header
      put_header(rcf_pkg::TAG_RIFF, 32'd4, TAG_WAVE);
      put_noise(2);
      send_file(1'b1);
      put_header(rcf_pkg::TAG_RIFX, 32'd0, 32'h0);
      send_file(1'b1);
      // declared end reached after one skipped chunk, rest ignored
      put_header(rcf_pkg::TAG_RIFF, 32'd16, TAG_WAVE);
      put_chunk(TAG_FMT, 32'd4, 1'b0, 4);
      put_noise(5);
      send_file(1'b1);
      // descriptor that starts before the end and crosses it
      put_header(rcf_pkg::TAG_RIFF, 32'd8, TAG_WAVE);
      put_chunk(rcf_pkg::TARGET_RESET, 32'd2, 1'b0, 2);
      send_file(1'b1);
      // zero-size chunk ahead of the target
      put_header(rcf_pkg::TAG_RIFF, 32'd25, TAG_WAVE);
      put_chunk(TAG_JUNK, 32'd0, 1'b0, 0);
      put_chunk(rcf_pkg::TARGET_RESET, 32'd5, 1'b0, 5);
      send_file(1'b1);
      // truncation inside a skip, then inside a descriptor
      put_header(rcf_pkg::TAG_RIFF, 32'd100, TAG_WAVE);
      put_chunk(TAG_LIST, 32'd30, 1'b0, 5);
      send_file(1'b1);
      put_header(rcf_pkg::TAG_RIFX, 32'd100, TAG_WAVE);
      put_word(TAG_FMT);
      put_noise(1);
      send_file(1'b1);
      // huge file and chunk sizes, cut short
      put_header(rcf_pkg::TAG_RIFF, 32'hffffffff, TAG_WAVE);
      put_chunk(TAG_JUNK, 32'hffffffff, 1'b0, 6);
      send_file(1'b1);
      // end of buffer on the byte that completes the found descriptor
      put_header(rcf_pkg::TAG_RIFF, 32'd12, TAG_WAVE);
      put_chunk(rcf_pkg::TARGET_RESET, 32'd7, 1'b0, 0);
      send_file(1'b1);

      // target extremes
      settle();
      write_target(32'h0);
      put_header(rcf_pkg::TAG_RIFF, 32'd32, TAG_WAVE);
      put_chunk(TAG_FMT, 32'd3, 1'b0, 3);
      put_chunk(32'h0, 32'd9, 1'b0, 9);
      send_file(1'b1);
      settle();
      write_target(32'hffffffff);
      put_header(rcf_pkg::TAG_RIFX, 32'd12, 32'h0);
      put_chunk(32'hffffffff, 32'd0, 1'b1, 0);
      send_file(1'b1);

      // target changed halfway through a tag; the value at its fourth byte counts
      put_header(rcf_pkg::TAG_RIFF, 32'd40, TAG_WAVE);
      put_word(TAG_FMT);
      put_size(32'd1, 1'b0);
      put_noise(1);
      file_buf.push_back(TAG_LIST[31:24]);
      file_buf.push_back(TAG_LIST[23:16]);
      send_file(1'b0);
      settle();
      write_target(TAG_LIST);
      file_buf.push_back(TAG_LIST[15:8]);
      file_buf.push_back(TAG_LIST[7:0]);
      put_size(32'd3, 1'b0);
      put_noise(3);
      send_file(1'b1);
      settle();
      write_target(rcf_pkg::TARGET_RESET);

      // random files in phases, each phase with its own idling and at times a new target
      while (sent_bytes < ITEM_TARGET) begin
         if ($urandom_range(5) == 0) begin
            settle();
            if ($urandom_range(1) == 1) begin
               write_target(pick_target());
            end
            req_gap_mode = $urandom_range(2);
            stall_mode = $urandom_range(2);
         end
         build_random_file();
         send_file(1'b1);
      end

      settle();
      if (board.mismatches == 0 && board.expected_reports.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rcf_pkg.sv
rtl/rcf_front.sv
rtl/rcf_queue.sv
rtl/rcf_back.sv
rtl/riff_chunk_finder.sv
rtl/rcf_checker.sv
sim/tb.sv
